FILE: src/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared types and constants for the prime test unit.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SPLIT,
    ST_ROUND,
    ST_EXP_BIT,
    ST_EXP_MUL,
    ST_EXP_SQR,
    ST_CHECK,
    ST_SQ_LOOP,
    ST_SQ_WAIT,
    ST_NEXT,
    ST_DONE
  } mrpt_state_t;

  localparam int unsigned NumWitness = 12;

  // Witness value for each round index.
  function automatic logic [5:0] witness(input logic [3:0] idx);
    logic [5:0] w;
    begin
      case (idx)
        4'd0:    w = 6'd2;
        4'd1:    w = 6'd3;
        4'd2:    w = 6'd5;
        4'd3:    w = 6'd7;
        4'd4:    w = 6'd11;
        4'd5:    w = 6'd13;
        4'd6:    w = 6'd17;
        4'd7:    w = 6'd19;
        4'd8:    w = 6'd23;
        4'd9:    w = 6'd29;
        4'd10:   w = 6'd31;
        4'd11:   w = 6'd37;
        default: w = 6'd2;
      endcase
      return w;
    end
  endfunction

  // Early exit limit after a round; zero means no limit.
  function automatic logic [63:0] limit(input logic short_list, input logic [3:0] idx);
    logic [63:0] l;
    begin
      l = 64'd0;
      if (short_list) begin
        case (idx)
          4'd0:    l = 64'd2047;
          4'd1:    l = 64'd1373653;
          4'd2:    l = 64'd25326001;
          default: l = 64'd0;
        endcase
      end else begin
        case (idx)
          4'd4:    l = 64'd2152302898747;
          4'd5:    l = 64'd3474749660383;
          4'd6:    l = 64'd341550071728321;
          4'd8:    l = 64'd3825123056546413051;
          default: l = 64'd0;
        endcase
      end
      return l;
    end
  endfunction

  localparam logic [63:0] SmallBound = 64'd3215031751;

endpackage

FILE: src/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Bit-serial shift-and-add product a*b mod m, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mrpt_mulmod
  import mrpt_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  logic             busy;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] mult;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] acc_sum;
  logic [WIDTH-1:0] add_dbl;
  logic [WIDTH:0]   acc_wide;
  logic [WIDTH:0]   dbl_wide;

  // Exact modular additions: operands are below the modulus, so one
  // subtraction suffices and the carry bit is kept.
  always_comb begin
    acc_wide = {1'b0, acc} + {1'b0, addend};
    dbl_wide = {1'b0, addend} + {1'b0, addend};
    acc_sum  = (acc_wide >= {1'b0, modulus}) ? WIDTH'(acc_wide - {1'b0, modulus})
                                              : acc_wide[WIDTH-1:0];
    add_dbl  = (dbl_wide >= {1'b0, modulus}) ? WIDTH'(dbl_wide - {1'b0, modulus})
                                              : dbl_wide[WIDTH-1:0];
  end

  // Sequencing of the serial product.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        acc     <= '0;
        addend  <= a;
        mult    <= b;
        modulus <= m;
      end else if (busy) begin
        if (mult == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (mult[0]) acc <= acc_sum;
          addend <= add_dbl;
          mult   <= mult >> 1;
        end
      end
    end
  end

  assign product = acc;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("start while busy");
  a_acc_below: assert property (@(posedge clk) disable iff (rst)
    done |-> acc < modulus) else $error("product not reduced");
`endif

endmodule

FILE: src/miller_rabin_prime_test_unit.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test unit
// Deterministic primality test of one unsigned candidate per request.
// ----------------------------------------------------------------------------
// One request is taken at a time; the unit is not ready until its result has
// been taken. Trivial cases finish without any round. An odd candidate runs up to
// four (below 3215031751) or twelve strong-probable-prime rounds, each a
// modular exponentiation and up to s-1 squarings, all on one bit-serial
// modular multiplier.
module miller_rabin_prime_test_unit
  import mrpt_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // candidate[63:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // is_prime[0], zero fill [7:1]
);

  mrpt_state_t      state, state_next;
  logic [WIDTH-1:0] n, d, e, v, base, nm1;
  logic [5:0]       s, r;
  logic [3:0]       wi;
  logic             short_list, verdict;
  logic             mul_start, mul_done;
  logic [WIDTH-1:0] mul_a, mul_b, mul_p;
  logic [63:0]      lim;
  logic [63:0]      n64;

  assign nm1 = n - WIDTH'(1);
  assign n64 = 64'(n);
  assign lim = limit(short_list, wi);

  mrpt_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .m(n),
    .done(mul_done), .product(mul_p)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_PREP;
      ST_PREP: begin
        if (n < WIDTH'(3) || !n[0]) state_next = ST_DONE;
        else state_next = ST_SPLIT;
      end
      ST_SPLIT:   if (d[0]) state_next = ST_ROUND;
      ST_ROUND:   state_next = ST_EXP_BIT;
      ST_EXP_BIT: begin
        if (e == '0) state_next = ST_CHECK;
        else if (e[0]) state_next = ST_EXP_MUL;
        else state_next = ST_EXP_SQR;
      end
      ST_EXP_MUL: if (mul_done) state_next = ST_EXP_SQR;
      ST_EXP_SQR: if (mul_done) state_next = ST_EXP_BIT;
      ST_CHECK: begin
        if (v == WIDTH'(1) || v == nm1) state_next = ST_NEXT;
        else state_next = ST_SQ_LOOP;
      end
      ST_SQ_LOOP: begin
        if (r >= s) state_next = ST_DONE;
        else state_next = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_done) begin
          if (mul_p == WIDTH'(1)) state_next = ST_DONE;
          else if (mul_p == nm1) state_next = ST_NEXT;
          else state_next = ST_SQ_LOOP;
        end
      end
      ST_NEXT: begin
        if ((lim != 64'd0 && n64 < lim) || (short_list && wi == 4'd3) ||
            wi == 4'(NumWitness - 1)) state_next = ST_DONE;
        else state_next = ST_ROUND;
      end
      ST_DONE:    if (m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs towards the handshake and the multiplier.
  always_comb begin
    s_tready  = (state == ST_IDLE);
    m_tvalid  = (state == ST_DONE);
    mul_start = 1'b0;
    mul_a     = v;
    mul_b     = base;
    case (state)
      ST_EXP_BIT: begin
        if (e != '0) begin
          mul_start = 1'b1;
          if (!e[0]) mul_a = base;
        end
      end
      ST_EXP_MUL: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = base;
        end
      end
      ST_SQ_LOOP: begin
        if (r < s) begin
          mul_start = 1'b1;
          mul_b     = v;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {7'd0, verdict};

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
    case (state)
      ST_IDLE: begin
        n <= s_tdata[WIDTH-1:0];
        verdict <= 1'b0;
      end
      ST_PREP: begin
        verdict    <= (n == WIDTH'(2));
        d          <= nm1;
        s          <= '0;
        wi         <= '0;
        short_list <= (n64 < SmallBound);
      end
      ST_SPLIT: begin
        if (!d[0]) begin
          d <= d >> 1;
          s <= s + 6'd1;
        end
      end
      ST_ROUND: begin
        if (WIDTH'(witness(wi)) >= n) base <= WIDTH'(witness(wi)) - n;
        else base <= WIDTH'(witness(wi));
        e <= d;
        v <= WIDTH'(1);
        r <= 6'd1;
      end
      ST_EXP_BIT: if (e != '0 && !e[0]) e <= e >> 1;
      ST_EXP_MUL: if (mul_done) begin
        v <= mul_p;
        e <= e >> 1;
      end
      ST_EXP_SQR: if (mul_done) base <= mul_p;
      ST_SQ_WAIT: if (mul_done) begin
        v <= mul_p;
        r <= r + 6'd1;
      end
      ST_NEXT: begin
        wi <= wi + 4'd1;
        if ((lim != 64'd0 && n64 < lim) || (short_list && wi == 4'd3) ||
            wi == 4'(NumWitness - 1)) verdict <= 1'b1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second request taken");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready while result pending");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Prime test unit testbench
// Drives candidates into the prime test unit with random idling on both
// sides, predicts each verdict from the directed table or with a local
// strong-probable-prime test and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import mrpt_pkg::*;

  localparam int unsigned NumRandom = 76;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // candidate[63:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // is_prime[0], zero fill [7:1]

  // Directed row: candidate and, where known at a glance, the verdict.
  typedef struct packed {
    logic [63:0] cand;
    logic        typed;
    logic        verdict;
  } cand_row_t;

  bit   verdict_q[$];
  int   err_count = 0;
  bit   drain_free;
  bit   send_free;

  miller_rabin_prime_test_unit #(.WIDTH(64)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Exact modular addition, x and y below m.
  function automatic logic [63:0] add_mod64(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] m);
    logic [64:0] sum;
    begin
      sum = {1'b0, x} + {1'b0, y};
      if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
      return sum[63:0];
    end
  endfunction

  // Modular product by shift and add.
  function automatic logic [63:0] mul_mod64(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
    logic [63:0] acc;
    begin
      acc = 64'd0;
      a = a % m;
      b = b % m;
      while (b != 0) begin
        if (b[0]) acc = add_mod64(acc, a, m);
        a = add_mod64(a, a, m);
        b = b >> 1;
      end
      return acc;
    end
  endfunction

  function automatic logic [63:0] pow_mod64(input logic [63:0] base, input logic [63:0] e,
                                            input logic [63:0] m);
    logic [63:0] x;
    begin
      x = (m == 64'd1) ? 64'd0 : 64'd1;
      base = base % m;
      while (e != 0) begin
        if (e[0]) x = mul_mod64(x, base, m);
        base = mul_mod64(base, base, m);
        e = e >> 1;
      end
      return x;
    end
  endfunction

  // One strong-probable-prime round for odd n >= 3.
  function automatic bit spp_pass(input logic [63:0] n, input logic [63:0] d,
                                  input int s, input logic [63:0] a);
    logic [63:0] v;
    begin
      v = pow_mod64(a, d, n);
      if (v == 64'd1 || v == n - 64'd1) return 1'b1;
      for (int r = 1; r < s; r++) begin
        v = mul_mod64(v, v, n);
        if (v == 64'd1) return 1'b0;
        if (v == n - 64'd1) return 1'b1;
      end
      return 1'b0;
    end
  endfunction

  // Deterministic primality verdict with the early-exit bounds.
  function automatic bit prime_verdict(input logic [63:0] n);
    logic [63:0] d;
    logic [63:0] bound;
    logic [5:0]  wits [12];
    int          s;
    int          rounds;
    bit          below;
    begin
      wits = '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29,
               6'd31, 6'd37};
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (!n[0]) return 1'b0;
      d = n - 64'd1;
      s = 0;
      while (!d[0]) begin
        d = d >> 1;
        s++;
      end
      below = (n < 64'd3215031751);
      rounds = below ? 4 : 12;
      for (int i = 0; i < rounds; i++) begin
        if (!spp_pass(n, d, s, {58'd0, wits[i]})) return 1'b0;
        bound = 64'd0;
        if (below) begin
          case (i)
            0: bound = 64'd2047;
            1: bound = 64'd1373653;
            2: bound = 64'd25326001;
            default: bound = 64'd0;
          endcase
        end else begin
          case (i)
            4: bound = 64'd2152302898747;
            5: bound = 64'd3474749660383;
            6: bound = 64'd341550071728321;
            8: bound = 64'd3825123056546413051;
            default: bound = 64'd0;
          endcase
        end
        if (bound != 0 && n < bound) return 1'b1;
      end
      return 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    begin
      $display("MISMATCH at %0t: %s", $realtime, what);
      err_count++;
    end
  endtask

  // Present one request and hold it until accepted; the valid line drops
  // only while idling, so a following request can start on the next edge.
  task automatic send_candidate(input logic [63:0] cand);
    begin
      while (!send_free && $urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= cand;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
  endtask

  // Random odd candidate of a given bit length.
  function automatic logic [63:0] rand_odd(input int bits);
    logic [63:0] v;
    begin
      v = {$urandom, $urandom};
      if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
      v[bits-1] = 1'b1;
      v[0] = 1'b1;
      return v;
    end
  endfunction

  // Result side: random back-pressure and comparison with predictions.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no prediction waiting");
        end else begin
          if (m_tdata[0] !== verdict_q[0])
            report_mismatch($sformatf("is_prime %0b, predicted %0b", m_tdata[0],
                                      verdict_q[0]));
          if (m_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("fill bits %0h not zero", m_tdata[7:1]));
          void'(verdict_q.pop_front());
        end
      end
      m_tready <= drain_free ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  // Stimulus: directed table, then random candidates.
  initial begin
    cand_row_t rows [$];
    logic [63:0] cand;
    int          sel;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 64'd0;
    drain_free = 1'b0;
    send_free  = 1'b0;
    rows = '{
      '{64'd0, 1'b1, 1'b0},
      '{64'd1, 1'b1, 1'b0},
      '{64'd2, 1'b1, 1'b1},
      '{64'd3, 1'b1, 1'b1},
      '{64'd4, 1'b1, 1'b0},
      '{64'd5, 1'b1, 1'b1},
      '{64'd7, 1'b1, 1'b1},
      '{64'd9, 1'b1, 1'b0},
      '{64'd2047, 1'b0, 1'b0},
      '{64'd1373653, 1'b0, 1'b0},
      '{64'd25326001, 1'b0, 1'b0},
      '{64'd3215031751, 1'b0, 1'b0},
      '{64'd3215031749, 1'b0, 1'b0},
      '{64'd2152302898747, 1'b0, 1'b0},
      '{64'd3474749660383, 1'b0, 1'b0},
      '{64'd341550071728321, 1'b0, 1'b0},
      '{64'd3825123056546413051, 1'b0, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFC5, 1'b1, 1'b1},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0},
      '{64'h8000_0000_0000_0001, 1'b0, 1'b0},
      '{64'h8000_0000_0000_001D, 1'b0, 1'b0},
      '{64'd4294967291, 1'b0, 1'b0},
      '{64'd561, 1'b1, 1'b0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_free = (i < 6);
      if (rows[i].typed) verdict_q.push_back(rows[i].verdict);
      else verdict_q.push_back(prime_verdict(rows[i].cand));
      send_candidate(rows[i].cand);
    end
    for (int k = 0; k < NumRandom; k++) begin
      send_free  = (k >= 40 && k < 55);
      drain_free = send_free;
      sel = $urandom_range(9);
      // Mostly small odd values; a few full-width ones and raw noise.
      case (sel)
        0, 1, 2, 3: cand = rand_odd($urandom_range(32, 2));
        4, 5:       cand = rand_odd($urandom_range(48, 33));
        6:          cand = rand_odd(64);
        7:          cand = {$urandom, $urandom};
        default:    cand = {$urandom, $urandom} >> $urandom_range(63, 30);
      endcase
      verdict_q.push_back(prime_verdict(cand));
      send_candidate(cand);
    end
    s_tvalid   <= 1'b0;
    drain_free = 1'b1;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #400000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
